FILE: hdl/pvsd_pkg.sv
// Package with constants, status codes and the length decode for the prefix varint decoder.
`timescale 1ns / 1ps
package pvsd_pkg;

	localparam logic [7:0] MARKER_BYTE  = 8'hFF;
	localparam logic [3:0] MAX_LEN      = 4'd9;
	localparam int unsigned BYTE_BITS   = 8;
	localparam int unsigned VALUE_BITS  = 64;
	localparam int unsigned LEN_BITS    = 4;

	typedef enum logic {
		STATUS_OK    = 1'b0,
		STATUS_TRUNC = 1'b1
	} status_t;

	function automatic logic [LEN_BITS-1:0] first_len(input logic [BYTE_BITS-1:0] b);
		logic [LEN_BITS-1:0] n;
		logic                run;
		n   = '0;
		run = 1'b1;
		if (b == MARKER_BYTE) begin
			n = MAX_LEN;
		end else begin
			for (int i = 0; i < BYTE_BITS; i++) begin
				run = run & b[i];
				n   = n + LEN_BITS'(run);
			end
			n = n + 4'd1;
		end
		return n;
	endfunction

endpackage

FILE: hdl/prefix_varint_stream_decoder.sv
// Prefix varint stream decoder: one byte per transaction, one result per complete varint.
// Path: input register, then result register; an output stall holds both registers.
// Throughput: one byte per cycle if unstalled; while a result waits one further byte is held.
// Multi-byte varints yield one result on their final byte, or a truncation at buffer end.
// Reset (arst_n low, asynchronous) drops any partial varint and empties both registers.
`timescale 1ns / 1ps
module prefix_varint_stream_decoder
	import pvsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_BITS-1:0]  in_byte,
	input  logic                  buffer_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] decoded_value,
	output logic [LEN_BITS-1:0]   encoded_length,
	output logic                  status
);

	logic                  valid_s1;
	logic [BYTE_BITS-1:0]  byte_s1;
	logic                  last_s1;

	logic [LEN_BITS-1:0]   needed_q;
	logic [LEN_BITS-1:0]   seen_q;
	logic [VALUE_BITS-1:0] accum_q;

	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [LEN_BITS-1:0]   length_q;
	status_t               status_q;

	logic                  advance;
	logic                  fire;
	logic                  start;
	logic [LEN_BITS-1:0]   len_first;
	logic [LEN_BITS-1:0]   pos_full;
	logic [2:0]            pos;
	logic [LEN_BITS-1:0]   nxt_needed;
	logic [LEN_BITS-1:0]   nxt_seen;
	logic [VALUE_BITS-1:0] nxt_accum;
	logic                  done;
	logic                  produce;
	logic [VALUE_BITS-1:0] done_value;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_comb begin
		start     = (needed_q == '0);
		len_first = first_len(byte_s1);
		pos_full  = (needed_q == MAX_LEN) ? seen_q - 4'd1 : seen_q;
		pos       = pos_full[2:0];
		if (start) begin
			nxt_needed = len_first;
			nxt_seen   = 4'd1;
			nxt_accum  = (len_first == MAX_LEN) ? '0 : VALUE_BITS'(byte_s1);
		end else begin
			nxt_needed = needed_q;
			nxt_seen   = seen_q + 4'd1;
			nxt_accum  = accum_q | (VALUE_BITS'(byte_s1) << {pos, 3'b000});
		end
		done       = (nxt_seen == nxt_needed);
		produce    = done || last_s1;
		done_value = (nxt_needed == MAX_LEN) ? nxt_accum : (nxt_accum >> nxt_needed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= buffer_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q <= '0;
			seen_q   <= '0;
			accum_q  <= '0;
		end else if (fire) begin
			if (produce) begin
				needed_q <= '0;
				seen_q   <= '0;
				accum_q  <= '0;
			end else begin
				needed_q <= nxt_needed;
				seen_q   <= nxt_seen;
				accum_q  <= nxt_accum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && produce) begin
			if (done) begin
				value_q  <= done_value;
				length_q <= nxt_needed;
				status_q <= STATUS_OK;
			end else begin
				value_q  <= '0;
				length_q <= '0;
				status_q <= STATUS_TRUNC;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign decoded_value  = value_q;
	assign encoded_length = length_q;
	assign status         = status_q;

	a_seen_below_needed: assert property (@(posedge clk) disable iff (!arst_n)
		needed_q != '0 |-> (seen_q < needed_q && needed_q <= MAX_LEN))
		else $error("partial varint count out of range");

	a_idle_state_clear: assert property (@(posedge clk) disable iff (!arst_n)
		needed_q == '0 |-> (seen_q == '0 && accum_q == '0))
		else $error("idle decoder holds stale state");

	a_ok_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_OK) |-> (length_q != '0 && length_q <= MAX_LEN))
		else $error("ok result with bad length");

	a_trunc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_TRUNC) |-> (length_q == '0 && value_q == '0))
		else $error("truncation result not zeroed");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && produce) |=> (needed_q == '0 && out_valid_q))
		else $error("state not cleared after result");

endmodule

FILE: tb/sv/pvsd_checker.sv
// Checker for the prefix varint decoder: predicts each result from accepted bytes and compares.
`timescale 1ns / 1ps
module pvsd_checker
	import pvsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [BYTE_BITS-1:0]  in_byte,
	input  logic                  buffer_last,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [VALUE_BITS-1:0] decoded_value,
	input  logic [LEN_BITS-1:0]   encoded_length,
	input  logic                  status,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [LEN_BITS-1:0]   length;
		status_t               stat;
	} varint_result_t;

	varint_result_t        results_due[$];
	logic [LEN_BITS-1:0]   need_len;
	logic [LEN_BITS-1:0]   seen_cnt;
	logic [VALUE_BITS-1:0] accum;
	int                    mismatches;

	function automatic logic [LEN_BITS-1:0] prefix_len(input logic [BYTE_BITS-1:0] b);
		int n;
		n = 0;
		if (b == MARKER_BYTE)
			return MAX_LEN;
		while (n < 8 && b[n])
			n++;
		return LEN_BITS'(n + 1);
	endfunction

	task automatic predict_varint(input logic [BYTE_BITS-1:0] b, input logic last);
		logic [LEN_BITS-1:0]   pos;
		logic [VALUE_BITS-1:0] v;
		logic                  done;
		done = 1'b0;
		if (need_len == 0 || need_len > MAX_LEN || seen_cnt >= need_len) begin
			need_len = prefix_len(b);
			seen_cnt = 4'd1;
			accum    = (need_len == MAX_LEN) ? '0 : VALUE_BITS'(b);
		end else begin
			pos      = (need_len == MAX_LEN) ? seen_cnt - 4'd1 : seen_cnt;
			accum    = accum | (VALUE_BITS'(b) << (8 * pos[2:0]));
			seen_cnt = seen_cnt + 4'd1;
		end
		if (seen_cnt == need_len) begin
			v = accum;
			if (need_len < MAX_LEN)
				v = (v >> need_len) & ((64'd1 << (7 * need_len)) - 64'd1);
			results_due.push_back('{value: v, length: need_len, stat: STATUS_OK});
			done = 1'b1;
		end else if (last) begin
			results_due.push_back('{value: '0, length: '0, stat: STATUS_TRUNC});
			done = 1'b1;
		end
		if (done) begin
			need_len = '0;
			seen_cnt = '0;
			accum    = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		varint_result_t exp_r;
		if (!arst_n) begin
			results_due.delete();
			need_len   = '0;
			seen_cnt   = '0;
			accum      = '0;
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_varint(in_byte, buffer_last);
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("unexpected result transaction: value %h length %0d status %0d",
						decoded_value, encoded_length, status);
					mismatches++;
				end else begin
					exp_r = results_due.pop_front();
					if (decoded_value !== exp_r.value) begin
						$error("decoded_value: expected %h, got %h", exp_r.value, decoded_value);
						mismatches++;
					end
					if (encoded_length !== exp_r.length) begin
						$error("encoded_length: expected %0d, got %0d", exp_r.length,
							encoded_length);
						mismatches++;
					end
					if (status !== exp_r.stat) begin
						$error("status: expected %s, got %0d", exp_r.stat.name(), status);
						mismatches++;
					end
				end
			end
			fail_count <= mismatches;
			pending    <= results_due.size();
		end
	end

endmodule

FILE: tb/sv/prefix_varint_stream_decoder_tb.sv
// Testbench top for the prefix varint decoder: clock, reset, byte stimulus, sink stalls, verdict.
`timescale 1ns / 1ps
module prefix_varint_stream_decoder_tb;
	import pvsd_pkg::*;

	typedef enum int {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_HALF,
		RX_RARELY
	} rx_mode_t;

	localparam int NUM_BYTES     = 1700;
	localparam int HOLD_OFF_AT   = 300;
	localparam int HOLD_OFF_LEN  = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [BYTE_BITS-1:0]  in_byte;
	logic                  buffer_last;
	logic                  out_valid;
	logic                  out_ready;
	logic [VALUE_BITS-1:0] decoded_value;
	logic [LEN_BITS-1:0]   encoded_length;
	logic                  status;
	int                    fail_count;
	int                    pending;
	int                    bytes_sent;
	int                    burst_left;
	bit                    hold_off_req;
	bit                    hold_off_done;

	prefix_varint_stream_decoder DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.buffer_last    (buffer_last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.decoded_value  (decoded_value),
		.encoded_length (encoded_length),
		.status         (status)
	);

	pvsd_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.buffer_last    (buffer_last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.decoded_value  (decoded_value),
		.encoded_length (encoded_length),
		.status         (status),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		in_byte     <= b;
		buffer_last <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_varint();
		int len;
		int cut;
		int fb;
		bit trunc;
		len   = $urandom_range(1, 9);
		trunc = (len > 1) && ($urandom_range(0, 7) == 0);
		cut   = trunc ? $urandom_range(1, len - 1) : len;
		if (len == MAX_LEN)
			fb = int'(MARKER_BYTE);
		else
			fb = ($urandom_range(0, 255) & ~((1 << len) - 1)) | ((1 << (len - 1)) - 1);
		for (int i = 0; i < cut; i++)
			send_byte((i == 0) ? BYTE_BITS'(fb) : BYTE_BITS'($urandom_range(0, 255)),
				trunc ? (i == cut - 1) : (i == len - 1 && $urandom_range(0, 3) == 0));
	endtask

	// receiver: stall in stretches of random style, once for a long hold-off
	initial begin
		rx_mode_t mode;
		int       len;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			len  = $urandom_range(8, 64);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					RX_ALWAYS: out_ready <= 1'b1;
					RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
					RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
					RX_RARELY: out_ready <= ($urandom_range(0, 4) == 0);
					default:   out_ready <= 1'b1;
				endcase
			end
			if (hold_off_req && !hold_off_done) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HOLD_OFF_LEN) @(negedge clk);
				hold_off_done = 1'b1;
			end
		end
	end

	initial begin
		logic [8:0] directed_seq[$];
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_byte       = '0;
		buffer_last   = 1'b0;
		bytes_sent    = 0;
		burst_left    = 0;
		hold_off_req  = 1'b0;
		// {buffer_last, byte}
		directed_seq = '{
			9'h000, 9'h0FE, 9'h100,
			9'h0FD, 9'h0FF,
			9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
			9'h003, 9'h1AA,
			9'h07F, 9'h001, 9'h023, 9'h045, 9'h067, 9'h089, 9'h0AB, 9'h0CD,
			9'h1FF
		};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_seq[i])
			send_byte(directed_seq[i][7:0], directed_seq[i][8]);

		while (bytes_sent < NUM_BYTES) begin
			if (bytes_sent >= HOLD_OFF_AT)
				hold_off_req = 1'b1;
			if ($urandom_range(0, 9) == 0)
				send_byte(BYTE_BITS'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			else
				send_varint();
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
